FILE: sv/tdt_greedy_decode_controller_unit_macros.svh
// Assertion macros used by the greedy decode controller RTL.
`ifndef TDT_GREEDY_DECODE_CONTROLLER_UNIT_MACROS_SVH
`define TDT_GREEDY_DECODE_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tdt_gdc_pkg.sv
// Types, codes and constants of the greedy decode controller.
package tdt_gdc_pkg;

    localparam int FRAME_BITS    = 16;
    localparam int MAX_DURATIONS = 8;
    localparam int POS_W         = FRAME_BITS + 1;
    localparam int TOKEN_W       = 16;
    localparam int ABS_W         = 32;
    localparam int DUR_W         = 4;
    localparam int DIDX_W        = 3;
    localparam int LABEL_W       = 8;
    localparam int TCNT_W        = 24;
    localparam int SYM_W         = 8;
    localparam int DCNT_W        = 4;
    localparam int DTAB_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLANK_TOKEN = 3'd0,
        CFG_MAX_SYMBOLS = 3'd1,
        CFG_TOKEN_LIMIT = 3'd2,
        CFG_DUR_TABLE   = 3'd3,
        CFG_DUR_COUNT   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_PREDICT = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY_CHUNK  = 2'd1,
        ST_BAD_DURATION = 2'd2,
        ST_IDLE_PREDICT = 2'd3
    } t_status;

    typedef struct packed {
        logic [TOKEN_W-1:0] blank_token;
        logic [SYM_W-1:0]   max_symbols;
        logic [TCNT_W-1:0]  token_limit;
        logic [DTAB_W-1:0]  dur_table;
        logic [DCNT_W-1:0]  dur_count;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]      frame_pos;
        logic [POS_W-1:0]      label_frame;
        logic                  last_label_valid;
        logic [LABEL_W-1:0]    labels_at_frame;
        logic [TCNT_W-1:0]     tokens_emitted;
        logic [TOKEN_W-1:0]    pending_token;
        logic                  predictor_valid;
        logic                  active;
        logic [FRAME_BITS-1:0] frames_in_chunk;
        logic [ABS_W-1:0]      frame_base;
        logic [TCNT_W-1:0]     chunk_token_limit;
    } t_state;

    typedef struct packed {
        t_action               action;
        logic                  clear_predictor;
        logic [FRAME_BITS-1:0] chunk_frames;
        logic [ABS_W-1:0]      chunk_offset;
        logic [TOKEN_W-1:0]    pred_token;
        logic [DIDX_W-1:0]     duration_index;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic                  done_res;
        logic [FRAME_BITS-1:0] next_frame;
        logic [TOKEN_W-1:0]    feed_token;
        logic                  recompute_predictor;
        logic                  emitted;
        logic [TOKEN_W-1:0]    emitted_token;
        logic [ABS_W-1:0]      emitted_frame;
        logic [DUR_W-1:0]      emitted_duration;
    } t_res;

    localparam t_cfg CFG_RESET = '{
        blank_token: TOKEN_W'(1024),
        max_symbols: SYM_W'(10),
        token_limit: '0,
        dur_table:   DTAB_W'(274960),
        dur_count:   DCNT_W'(5)
    };

    localparam t_state STATE_RESET = '{
        frame_pos:         '0,
        label_frame:       '0,
        last_label_valid:  1'b0,
        labels_at_frame:   '0,
        tokens_emitted:    '0,
        pending_token:     TOKEN_W'(1024),
        predictor_valid:   1'b0,
        active:            1'b0,
        frames_in_chunk:   '0,
        frame_base:        '0,
        chunk_token_limit: '0
    };

endpackage

FILE: sv/tdt_gdc_in_if.sv
// Input channel of the decode controller: start and prediction words.
interface tdt_gdc_in_if;
    import tdt_gdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic                  clear_predictor;
    logic [FRAME_BITS-1:0] chunk_frames;
    logic [ABS_W-1:0]      chunk_offset;
    logic [TOKEN_W-1:0]    pred_token;
    logic [DIDX_W-1:0]     duration_index;

    modport source (
        output valid, action, clear_predictor, chunk_frames, chunk_offset,
               pred_token, duration_index,
        input  ready
    );

    modport sink (
        input  valid, action, clear_predictor, chunk_frames, chunk_offset,
               pred_token, duration_index,
        output ready
    );
endinterface

FILE: sv/tdt_gdc_out_if.sv
// Result channel of the decode controller.
interface tdt_gdc_out_if;
    import tdt_gdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  done_res;
    logic [FRAME_BITS-1:0] next_frame;
    logic [TOKEN_W-1:0]    feed_token;
    logic                  recompute_predictor;
    logic                  emitted;
    logic [TOKEN_W-1:0]    emitted_token;
    logic [ABS_W-1:0]      emitted_frame;
    logic [DUR_W-1:0]      emitted_duration;

    modport source (
        output valid, status, done_res, next_frame, feed_token, recompute_predictor,
               emitted, emitted_token, emitted_frame, emitted_duration,
        input  ready
    );

    modport sink (
        input  valid, status, done_res, next_frame, feed_token, recompute_predictor,
               emitted, emitted_token, emitted_frame, emitted_duration,
        output ready
    );
endinterface

FILE: sv/tdt_gdc_step.sv
// Next-state and result logic for one decode word.
module tdt_gdc_step (
    input  tdt_gdc_pkg::t_cfg     i_cfg,
    input  tdt_gdc_pkg::t_state   i_state,
    input  tdt_gdc_pkg::t_in_word i_word,
    output tdt_gdc_pkg::t_state   o_state,
    output tdt_gdc_pkg::t_res     o_res
);
    import tdt_gdc_pkg::*;

    logic [SYM_W-1:0]   sym;
    logic [DCNT_W-1:0]  dcount;
    logic [DUR_W-1:0]   dur;
    logic               is_blank;
    logic               same_frame;
    logic [LABEL_W-1:0] labels_new;
    logic               force_step;
    logic [POS_W-1:0]   pos_next;
    t_state             ns;
    t_status            status;
    logic               emit;

    assign sym    = (i_cfg.max_symbols == '0) ? SYM_W'(1) : i_cfg.max_symbols;
    assign dcount = (i_cfg.dur_count > DCNT_W'(MAX_DURATIONS)) ?
                    DCNT_W'(MAX_DURATIONS) : i_cfg.dur_count;
    assign dur    = i_cfg.dur_table[{i_word.duration_index, 2'b00} +: DUR_W];

    assign is_blank   = (i_word.pred_token == i_cfg.blank_token);
    assign same_frame = i_state.last_label_valid &&
                        (i_state.frame_pos == i_state.label_frame);
    assign labels_new = !same_frame                  ? LABEL_W'(1) :
                        (&i_state.labels_at_frame)   ? i_state.labels_at_frame :
                        i_state.labels_at_frame + LABEL_W'(1);

    // zero duration moves on by one frame for a blank or a saturated frame
    assign force_step = (dur == '0) && (is_blank || (labels_new >= sym));
    assign pos_next   = i_state.frame_pos + POS_W'(dur) + POS_W'(force_step);

    always_comb begin
        ns     = i_state;
        status = ST_OK;
        emit   = 1'b0;
        unique case (i_word.action)
            ACT_START: begin
                if (i_word.clear_predictor) begin
                    ns.pending_token   = i_cfg.blank_token;
                    ns.predictor_valid = 1'b0;
                end
                ns.frame_pos         = '0;
                ns.label_frame       = '0;
                ns.last_label_valid  = 1'b0;
                ns.labels_at_frame   = '0;
                ns.tokens_emitted    = '0;
                ns.frames_in_chunk   = i_word.chunk_frames;
                ns.frame_base        = i_word.chunk_offset;
                ns.chunk_token_limit = (i_cfg.token_limit != '0) ? i_cfg.token_limit :
                                       TCNT_W'(i_word.chunk_frames) * TCNT_W'(sym);
                ns.active            = (i_word.chunk_frames != '0);
                if (i_word.chunk_frames == '0) begin
                    status = ST_EMPTY_CHUNK;
                end
            end
            ACT_PREDICT: begin
                priority if (!i_state.active) begin
                    status = ST_IDLE_PREDICT;
                end else if ({1'b0, i_word.duration_index} >= dcount) begin
                    ns.predictor_valid = 1'b1;
                    ns.pending_token   = i_word.pred_token;
                    ns.active          = 1'b0;
                    status             = ST_BAD_DURATION;
                end else begin
                    ns.predictor_valid = 1'b1;
                    ns.pending_token   = i_word.pred_token;
                    if (!is_blank) begin
                        emit                = 1'b1;
                        ns.label_frame      = i_state.frame_pos;
                        ns.last_label_valid = 1'b1;
                        ns.labels_at_frame  = labels_new;
                        ns.tokens_emitted   = i_state.tokens_emitted + TCNT_W'(1);
                    end
                    ns.frame_pos = pos_next;
                    ns.active    = !((pos_next >= POS_W'(i_state.frames_in_chunk)) ||
                                     (ns.tokens_emitted >= i_state.chunk_token_limit));
                end
            end
        endcase
    end

    assign o_state = ns;

    always_comb begin
        o_res.status              = status;
        o_res.done_res            = !ns.active;
        o_res.next_frame          = ns.active ? ns.frame_pos[FRAME_BITS-1:0] : '0;
        o_res.feed_token          = ns.pending_token;
        o_res.recompute_predictor = !ns.predictor_valid ||
                                    (ns.pending_token != i_cfg.blank_token);
        o_res.emitted             = emit;
        o_res.emitted_token       = emit ? i_word.pred_token : '0;
        o_res.emitted_frame       = emit ? i_state.frame_base + ABS_W'(i_state.frame_pos)
                                         : '0;
        o_res.emitted_duration    = emit ? dur : '0;
    end

endmodule

FILE: sv/tdt_greedy_decode_controller_unit.sv
// Top level of the greedy token-and-duration decode controller.
//
//  channel   dir  handshake            word
//  i_in      in   valid/ready          start (frames, offset) or prediction (token, dur idx)
//  o_out     out  valid/ready          status, next frame, feed token, emission
//  i_cfg_*   in   write enable only    register index and data, no read-back
//
// One word per cycle sustained while o_out.ready stays high; o_out presents registered results.
// The words pass an input register, one step of decode logic and a result register.
// i_in.ready stays high while the result register is empty or being drained.
// Synchronous active-low reset clears the chunk state and restores register defaults.
`include "tdt_greedy_decode_controller_unit_macros.svh"

module tdt_greedy_decode_controller_unit (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    tdt_gdc_in_if.sink                                 i_in,
    tdt_gdc_out_if.source                              o_out,
    input  logic                                       i_cfg_we,
    input  logic [tdt_gdc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [tdt_gdc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import tdt_gdc_pkg::*;

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    logic     r_in_vld;
    t_in_word r_in;
    logic     r_out_vld;
    t_res     r_out;
    t_res     n_out;
    logic     in_take;
    logic     advance;

    assign advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BLANK_TOKEN: r_cfg.blank_token <= i_cfg_data[TOKEN_W-1:0];
                CFG_MAX_SYMBOLS: r_cfg.max_symbols <= i_cfg_data[SYM_W-1:0];
                CFG_TOKEN_LIMIT: r_cfg.token_limit <= i_cfg_data[TCNT_W-1:0];
                CFG_DUR_TABLE:   r_cfg.dur_table   <= i_cfg_data[DTAB_W-1:0];
                CFG_DUR_COUNT:   r_cfg.dur_count   <= i_cfg_data[DCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action          <= t_action'(i_in.action);
            r_in.clear_predictor <= i_in.clear_predictor;
            r_in.chunk_frames    <= i_in.chunk_frames;
            r_in.chunk_offset    <= i_in.chunk_offset;
            r_in.pred_token      <= i_in.pred_token;
            r_in.duration_index  <= i_in.duration_index;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= STATE_RESET;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    tdt_gdc_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_word  (r_in),
        .o_state (n_state),
        .o_res   (n_out)
    );

    assign o_out.valid               = r_out_vld;
    assign o_out.status              = r_out.status;
    assign o_out.done_res            = r_out.done_res;
    assign o_out.next_frame          = r_out.next_frame;
    assign o_out.feed_token          = r_out.feed_token;
    assign o_out.recompute_predictor = r_out.recompute_predictor;
    assign o_out.emitted             = r_out.emitted;
    assign o_out.emitted_token       = r_out.emitted_token;
    assign o_out.emitted_frame       = r_out.emitted_frame;
    assign o_out.emitted_duration    = r_out.emitted_duration;

    `TDT_ASSERT_NEXT(a_in_word_kept, i_clk, i_rst_n, r_in_vld && !advance, r_in_vld,
        "pending input word dropped")
    `TDT_ASSERT_IMPLY(a_err_closes, i_clk, i_rst_n, r_out_vld && (r_out.status != ST_OK),
        r_out.done_res, "error status without done")
    `TDT_ASSERT_IMPLY(a_emit_ok, i_clk, i_rst_n, r_out_vld && r_out.emitted,
        r_out.status == ST_OK, "emission with error status")
    `TDT_ASSERT_IMPLY(a_done_frame, i_clk, i_rst_n, r_out_vld && r_out.done_res,
        r_out.next_frame == '0, "next frame set while done")

endmodule
